>>> rtl/akt_pkg.sv
// Shared types and codes for the associative key table.
package akt_pkg;

  // Operation codes
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_AT_IDX = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam int MAX_KEY_WORDS = 4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] ident;
    logic [63:0] key_in0;
    logic [63:0] key_in1;
    logic [63:0] key_in2;
    logic [63:0] key_in3;
    logic [31:0] tag_in;
    logic [7:0]  position;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] key_out0;
    logic [63:0] key_out1;
    logic [63:0] key_out2;
    logic [63:0] key_out3;
    logic [31:0] tag_out;
    logic [63:0] ident_out;
    logic [4:0]  entry_count;
  } out_t;

  // Contents of one table entry as seen at a cell boundary
  typedef struct packed {
    logic [63:0]                          ident;
    logic [MAX_KEY_WORDS-1:0][63:0]       key;
    logic [31:0]                          tag;
  } entry_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic                                 cmp;
    logic                                 set_wr;
    logic                                 rm_shift;
    logic [63:0]                          id;
    logic [MAX_KEY_WORDS-1:0][63:0]       key;
    logic [31:0]                          tag;
    logic [7:0]                           position;
  } cmd_t;

endpackage

>>> rtl/akt_cell.sv
// One table cell: stores an entry, compares it with the broadcast identifier and its place with the broadcast position.
module akt_cell #(
  parameter int IDX       = 0,
  parameter int KEY_WORDS = 4,
  parameter int CNT_W     = 5,
  parameter int IDX_W     = 4
) (
  input  logic               clk,
  input  akt_pkg::cmd_t      cmd,
  input  logic [CNT_W-1:0]   count,
  input  logic [IDX_W-1:0]   tgt,
  input  akt_pkg::entry_t    nbr,
  output akt_pkg::entry_t    ent,
  output logic               hit,
  output logic               pos_hit
);
  import akt_pkg::*;

  logic [63:0]                ident_r;
  logic [KEY_WORDS-1:0][63:0] key_r;
  logic [31:0]                tag_r;
  logic                       hit_r;
  logic                       pos_hit_r;
  logic                       in_range;

  // Cell holds a live entry when its place is below the count
  assign in_range = CNT_W'(IDX) < count;

  // Compare, write on set, take the upper neighbour's entry on remove
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      hit_r     <= in_range && (ident_r == cmd.id);
      pos_hit_r <= in_range && (8'(IDX) == cmd.position);
    end
    if (cmd.set_wr && (IDX_W'(IDX) == tgt)) begin
      ident_r <= cmd.id;
      for (int w = 0; w < KEY_WORDS; w++) begin
        key_r[w] <= cmd.key[w];
      end
      tag_r <= cmd.tag;
    end else if (cmd.rm_shift && (IDX_W'(IDX) >= tgt) && in_range) begin
      ident_r <= nbr.ident;
      for (int w = 0; w < KEY_WORDS; w++) begin
        key_r[w] <= nbr.key[w];
      end
      tag_r <= nbr.tag;
    end
  end

  // Present the entry, unused key words zero
  always_comb begin
    ent.ident = ident_r;
    ent.tag   = tag_r;
    for (int w = 0; w < MAX_KEY_WORDS; w++) begin
      if (w < KEY_WORDS) begin
        ent.key[w] = key_r[w];
      end else begin
        ent.key[w] = '0;
      end
    end
  end

  assign hit     = hit_r;
  assign pos_hit = pos_hit_r;

endmodule

>>> rtl/associative_key_table_unit.sv
// Associative key table: a row of entry cells and the operation sequencer.
//
// An operation runs through the compare, encode and commit states from start to
// the next accepted start: in S_CMP every cell compares its identifier with the
// request, in S_ENC the match is encoded and the result registered, and in
// S_DONE out_valid strobes the result while the cells commit the update; busy
// is low in S_DONE so the next start is taken at its end. The result strobe
// comes in S_DONE and lasts one cycle; the receiver cannot stall it.
// entry_count reports the count after the operation. Entries are kept in
// insertion order with no gaps; remove moves every later entry down one cell
// in that commit cycle.
module associative_key_table_unit #(
  parameter int CAPACITY    = 16,
  parameter int IDENT_BYTES = 8,
  parameter int KEY_WORDS   = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  akt_pkg::in_t   in_data,
  output logic           out_valid,
  output akt_pkg::out_t  out_data
);
  import akt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_ENC  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic                           accept;
  logic [63:0]                    id_canon;
  logic [1:0]                     op_r;
  logic [63:0]                    id_r;
  logic [MAX_KEY_WORDS-1:0][63:0] key_r;
  logic [31:0]                    tag_r;
  logic [7:0]                     position_r;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [IDX_W-1:0]               tgt_r, tgt_nxt;
  logic                           do_set_r, do_set_nxt;
  logic                           do_rm_r, do_rm_nxt;
  logic                           out_valid_r;
  out_t                           res_r, res_nxt;
  cmd_t                           cmd;
  entry_t                         ent [CAPACITY];
  logic [CAPACITY-1:0]            hit;
  logic [CAPACITY-1:0]            pos_hit;
  logic                           found;
  logic                           at_ok;
  logic [IDX_W-1:0]               hit_idx;
  entry_t                         hit_ent;
  logic [63:0]                    at_ident;
  logic [8:0]                     cnt_ext;

  assign busy   = (state_r == S_CMP) || (state_r == S_ENC);
  assign accept = start && !busy;

  // Keep characters up to the first zero byte, within the identifier length
  always_comb begin
    logic alive;
    alive    = 1'b1;
    id_canon = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < IDENT_BYTES && alive && (in_data.ident[8*b +: 8] != 8'd0)) begin
        id_canon[8*b +: 8] = in_data.ident[8*b +: 8];
      end else begin
        alive = 1'b0;
      end
    end
  end

  // Sequencer state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_ENC;
      S_ENC:   state_nxt = S_DONE;
      S_DONE:  state_nxt = accept ? S_CMP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Latch the request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_data.opcode;
      id_r       <= id_canon;
      key_r[0]   <= in_data.key_in0;
      key_r[1]   <= in_data.key_in1;
      key_r[2]   <= in_data.key_in2;
      key_r[3]   <= in_data.key_in3;
      tag_r      <= in_data.tag_in;
      position_r <= in_data.position;
    end
  end

  // Broadcast to the cells
  always_comb begin
    cmd.cmp      = (state_r == S_CMP);
    cmd.set_wr   = (state_r == S_DONE) && do_set_r;
    cmd.rm_shift = (state_r == S_DONE) && do_rm_r;
    cmd.id       = id_r;
    cmd.key      = key_r;
    cmd.tag      = tag_r;
    cmd.position = position_r;
  end

  // Row of cells, each fed by its upper neighbour (the last by its own entry)
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t nbr;
    if (g == CAPACITY - 1) begin : g_last
      assign nbr = ent[g];
    end else begin : g_mid
      assign nbr = ent[g+1];
    end
    akt_cell #(
      .IDX       (g),
      .KEY_WORDS (KEY_WORDS),
      .CNT_W     (CNT_W),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .count   (count_r),
      .tgt     (tgt_r),
      .nbr     (nbr),
      .ent     (ent[g]),
      .hit     (hit[g]),
      .pos_hit (pos_hit[g])
    );
  end

  // Encode the single match and select the matching entries
  always_comb begin
    hit_idx  = '0;
    hit_ent  = '0;
    at_ident = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_ent = hit_ent | ent[i];
      end
      if (pos_hit[i]) begin
        at_ident = at_ident | ent[i].ident;
      end
    end
  end

  assign found = |hit;
  assign at_ok = |pos_hit;

  // Decide the outcome of the operation
  always_comb begin
    res_nxt    = '0;
    res_nxt.status = ST_OK;
    count_nxt  = count_r;
    tgt_nxt    = hit_idx;
    do_set_nxt = 1'b0;
    do_rm_nxt  = 1'b0;
    case (op_r)
      OP_SET: begin
        if (id_r == 64'd0) begin
          res_nxt.status = ST_INVALID;
        end else if (found) begin
          do_set_nxt = 1'b1;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          res_nxt.status = ST_FULL;
        end else begin
          tgt_nxt    = IDX_W'(count_r);
          count_nxt  = count_r + CNT_W'(1);
          do_set_nxt = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (found) begin
          res_nxt.key_out0 = hit_ent.key[0];
          res_nxt.key_out1 = hit_ent.key[1];
          res_nxt.key_out2 = hit_ent.key[2];
          res_nxt.key_out3 = hit_ent.key[3];
          res_nxt.tag_out  = hit_ent.tag;
        end else begin
          res_nxt.status = ST_NOT_FOUND;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          count_nxt = count_r - CNT_W'(1);
          do_rm_nxt = 1'b1;
        end else begin
          res_nxt.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (at_ok) begin
          res_nxt.ident_out = at_ident;
        end else begin
          res_nxt.status = ST_NOT_FOUND;
        end
      end
    endcase
    cnt_ext = 9'(count_nxt);
    res_nxt.entry_count = cnt_ext[4:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      do_set_r    <= 1'b0;
      do_rm_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_ENC);
      if (state_r == S_ENC) begin
        count_r  <= count_nxt;
        do_set_r <= do_set_nxt;
        do_rm_r  <= do_rm_nxt;
      end
    end
  end

  // Result and commit target
  always_ff @(posedge clk) begin
    if (state_r == S_ENC) begin
      res_r <= res_nxt;
      tgt_r <= tgt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // Identifiers are unique, so at most one cell may match
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENC) |-> $onehot0(hit))
    else $error("more than one cell matched");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_strobe_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_DONE))
    else $error("result strobe outside the commit cycle");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENC) && do_rm_nxt |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("remove did not drop the count");

  a_set_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENC) && (op_r == OP_SET) && !found && (count_r == CNT_W'(CAPACITY))
    |-> !do_set_nxt)
    else $error("append on a full table");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the associative key table: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_top;
  import akt_pkg::*;

  localparam int TBL_DEPTH   = 16;
  localparam int ID_BYTES    = 8;
  localparam int KEY_WORDS   = 4;
  localparam int POOL_SIZE   = 24;
  localparam int SEG_ITEMS   = 60;
  localparam int SEG_COUNT   = 25;
  localparam int DRAIN_WAIT  = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTS  = 40;

  typedef enum int {SEG_MIX, SEG_FILL, SEG_DRAIN} seg_mode_t;

  typedef struct {
    in_t  item;
    int   rep;
    bit   typed;
    out_t res;
  } dir_row_t;

  logic clk;
  logic rst_n       = 1'b0;
  logic start       = 1'b0;
  logic busy;
  in_t  in_data     = '0;
  logic out_valid;
  out_t out_data;

  // Hand-typed expectation that travels with a directed beat
  logic fixed_valid = 1'b0;
  out_t fixed_res   = '0;

  // Shadow copy of the table contents
  logic [63:0] tbl_ident [TBL_DEPTH];
  logic [63:0] tbl_key   [TBL_DEPTH][KEY_WORDS];
  logic [31:0] tbl_tag   [TBL_DEPTH];
  int          n_entries = 0;

  out_t        pending_res [$];
  dir_row_t    rows [$];
  logic [63:0] id_pool [POOL_SIZE];
  int          id_len  [POOL_SIZE];
  int          err_count = 0;
  int          n_accepted = 0;
  int          n_results = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  int          cycles = 0;

  associative_key_table_unit #(
    .CAPACITY   (TBL_DEPTH),
    .IDENT_BYTES(ID_BYTES),
    .KEY_WORDS  (KEY_WORDS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Keep the characters up to the first zero byte
  function automatic logic [63:0] trim_ident(logic [63:0] raw);
    logic [63:0] id;
    bit          ended;
    id = '0;
    ended = 1'b0;
    for (int i = 0; i < ID_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'h00) ended = 1'b1;
      if (!ended) id[8*i +: 8] = raw[8*i +: 8];
    end
    return id;
  endfunction

  function automatic int locate_ident(logic [63:0] id);
    for (int i = 0; i < n_entries; i++) begin
      if (tbl_ident[i] == id) return i;
    end
    return n_entries;
  endfunction

  // Apply one operation to the shadow table and return the result it gives
  function automatic out_t table_apply(in_t cmd);
    out_t        res;
    logic [63:0] id;
    int          pos;
    res = '0;
    id = trim_ident(cmd.ident);
    pos = locate_ident(id);
    res.status = ST_OK;
    case (cmd.opcode)
      OP_SET: begin
        if (id == '0) begin
          res.status = ST_INVALID;
        end else if (pos == n_entries && n_entries >= TBL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (pos == n_entries) begin
            tbl_ident[pos] = id;
            n_entries++;
          end
          tbl_key[pos][0] = cmd.key_in0;
          tbl_key[pos][1] = cmd.key_in1;
          tbl_key[pos][2] = cmd.key_in2;
          tbl_key[pos][3] = cmd.key_in3;
          tbl_tag[pos] = cmd.tag_in;
        end
      end
      OP_LOOKUP: begin
        if (id == '0 || pos == n_entries) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.key_out0 = tbl_key[pos][0];
          res.key_out1 = tbl_key[pos][1];
          res.key_out2 = tbl_key[pos][2];
          res.key_out3 = tbl_key[pos][3];
          res.tag_out  = tbl_tag[pos];
        end
      end
      OP_REMOVE: begin
        if (id == '0 || pos == n_entries) begin
          res.status = ST_NOT_FOUND;
        end else begin
          // Close the gap: move every later entry down one place
          for (int j = pos; j + 1 < n_entries; j++) begin
            tbl_ident[j] = tbl_ident[j+1];
            tbl_tag[j] = tbl_tag[j+1];
            for (int w = 0; w < KEY_WORDS; w++) tbl_key[j][w] = tbl_key[j+1][w];
          end
          n_entries--;
        end
      end
      OP_AT_IDX: begin
        if (int'(cmd.position) >= n_entries) res.status = ST_NOT_FOUND;
        else res.ident_out = tbl_ident[cmd.position];
      end
    endcase
    res.entry_count = n_entries[4:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
  endtask

  task automatic check_fields(out_t got, out_t want);
    if (got.status !== want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
    if (got.key_out0 !== want.key_out0) report_mismatch("key_out0", got.key_out0, want.key_out0);
    if (got.key_out1 !== want.key_out1) report_mismatch("key_out1", got.key_out1, want.key_out1);
    if (got.key_out2 !== want.key_out2) report_mismatch("key_out2", got.key_out2, want.key_out2);
    if (got.key_out3 !== want.key_out3) report_mismatch("key_out3", got.key_out3, want.key_out3);
    if (got.tag_out !== want.tag_out)
      report_mismatch("tag_out", 64'(got.tag_out), 64'(want.tag_out));
    if (got.ident_out !== want.ident_out)
      report_mismatch("ident_out", got.ident_out, want.ident_out);
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
  endtask

  // Predict on every accepted beat, check every result strobe against the oldest entry
  always @(posedge clk) begin : mon_p
    out_t want;
    if (rst_n) begin
      if (start && !busy) begin
        want = table_apply(in_data);
        if (fixed_valid) want = fixed_res;
        pending_res.push_back(want);
        n_accepted++;
      end
      if (out_valid) begin
        if (pending_res.size() == 0) begin
          report_mismatch("result with nothing pending", out_data.ident_out, '0);
        end else begin
          want = pending_res.pop_front();
          check_fields(out_data, want);
          n_results++;
          status_seen[out_data.status]++;
        end
      end
    end
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_res.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic out_t mk_res(logic [1:0] st, logic [63:0] kw, logic [31:0] tg,
                                  logic [63:0] id_out, int cnt);
    out_t res;
    res.status      = st;
    res.key_out0    = kw;
    res.key_out1    = kw;
    res.key_out2    = kw;
    res.key_out3    = kw;
    res.tag_out     = tg;
    res.ident_out   = id_out;
    res.entry_count = cnt[4:0];
    return res;
  endfunction

  task automatic add_row(logic [1:0] op, logic [63:0] id, logic [63:0] kw, logic [31:0] tg,
                         logic [7:0] pos, int rep, bit typed, out_t res);
    dir_row_t row;
    row.item.opcode   = op;
    row.item.ident    = id;
    row.item.key_in0  = kw;
    row.item.key_in1  = kw;
    row.item.key_in2  = kw;
    row.item.key_in3  = kw;
    row.item.tag_in   = tg;
    row.item.position = pos;
    row.rep   = rep;
    row.typed = typed;
    row.res   = res;
    rows.push_back(row);
  endtask

  // Offer one beat after an idle gap and hold it until the block takes it
  task automatic send(in_t item, bit typed, out_t res, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_data     <= item;
    fixed_valid <= typed;
    fixed_res   <= res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // Mostly identifiers from the pool, some with junk after the terminator
  function automatic logic [63:0] rand_ident();
    int          sel;
    int          k;
    logic [63:0] raw;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      raw = {$urandom(), $urandom()};
      raw[7:0] = 8'h00;
    end else if (sel < 15) begin
      raw = {$urandom(), $urandom()};
    end else begin
      k = $urandom_range(0, POOL_SIZE - 1);
      raw = id_pool[k];
      if (id_len[k] < 8 && $urandom_range(0, 2) == 0)
        raw = raw | ({$urandom(), $urandom()} << (8 * (id_len[k] + 1)));
    end
    return raw;
  endfunction

  function automatic in_t gen_item(seg_mode_t mode);
    in_t item;
    int  w;
    w = $urandom_range(0, 99);
    case (mode)
      SEG_FILL:
        item.opcode = w < 70 ? OP_SET : w < 80 ? OP_LOOKUP : w < 85 ? OP_REMOVE : OP_AT_IDX;
      SEG_DRAIN:
        item.opcode = w < 10 ? OP_SET : w < 25 ? OP_LOOKUP : w < 85 ? OP_REMOVE : OP_AT_IDX;
      default:
        item.opcode = w < 35 ? OP_SET : w < 60 ? OP_LOOKUP : w < 75 ? OP_REMOVE : OP_AT_IDX;
    endcase
    item.ident   = rand_ident();
    item.key_in0 = rand_word();
    item.key_in1 = rand_word();
    item.key_in2 = rand_word();
    item.key_in3 = rand_word();
    item.tag_in  = $urandom();
    if ($urandom_range(0, 6) == 0) item.position = 8'($urandom_range(0, 255));
    else item.position = 8'($urandom_range(0, TBL_DEPTH + 1));
    return item;
  endfunction

  // Build a pool of distinct identifiers of every length
  task automatic build_pool();
    bit dup;
    for (int k = 0; k < POOL_SIZE; k++) begin
      do begin
        id_len[k] = (k < 8) ? k + 1 : $urandom_range(1, 8);
        id_pool[k] = '0;
        for (int b = 0; b < id_len[k]; b++) id_pool[k][8*b +: 8] = 8'($urandom_range(1, 255));
        dup = 1'b0;
        for (int m = 0; m < k; m++) if (id_pool[m] == id_pool[k]) dup = 1'b1;
      end while (dup);
    end
  endtask

  initial begin : stim_p
    in_t       item;
    seg_mode_t mode;
    bit        quiet;
    int        gap;

    build_pool();

    // Directed table: empty-table misses, empty identifiers, extremes, full table, removal
    add_row(OP_LOOKUP, 64'h41, '0, '0, 8'd0, 1, 1'b1, mk_res(ST_NOT_FOUND, '0, '0, '0, 0));
    add_row(OP_AT_IDX, '0, '0, '0, 8'd0, 1, 1'b1, mk_res(ST_NOT_FOUND, '0, '0, '0, 0));
    add_row(OP_REMOVE, 64'h41, '0, '0, 8'd0, 1, 1'b1, mk_res(ST_NOT_FOUND, '0, '0, '0, 0));
    add_row(OP_SET, '0, '1, '1, 8'd0, 1, 1'b1, mk_res(ST_INVALID, '0, '0, '0, 0));
    add_row(OP_SET, 64'hFFFF_FFFF_FFFF_FF00, '1, '1, 8'd0, 1, 1'b1,
            mk_res(ST_INVALID, '0, '0, '0, 0));
    add_row(OP_SET, '1, '1, '1, 8'hFF, 1, 1'b1, mk_res(ST_OK, '0, '0, '0, 1));
    add_row(OP_LOOKUP, '1, '0, '0, 8'd0, 1, 1'b1, mk_res(ST_OK, '1, '1, '0, 1));
    add_row(OP_SET, 64'h41, '0, '0, 8'd0, 1, 1'b1, mk_res(ST_OK, '0, '0, '0, 2));
    add_row(OP_SET, 64'hAA00_0000_0000_0041, 64'h0123_4567_89AB_CDEF, 32'h1234_5678, 8'd0,
            1, 1'b1, mk_res(ST_OK, '0, '0, '0, 2));
    add_row(OP_LOOKUP, 64'h5500_0000_0000_0041, '0, '0, 8'd0, 1, 1'b0, '0);
    add_row(OP_AT_IDX, '0, '0, '0, 8'd1, 1, 1'b1, mk_res(ST_OK, '0, '0, 64'h41, 2));
    add_row(OP_AT_IDX, '0, '0, '0, 8'hFF, 1, 1'b1, mk_res(ST_NOT_FOUND, '0, '0, '0, 2));
    add_row(OP_LOOKUP, '0, '0, '0, 8'd0, 1, 1'b1, mk_res(ST_NOT_FOUND, '0, '0, '0, 2));
    add_row(OP_REMOVE, '0, '0, '0, 8'd0, 1, 1'b1, mk_res(ST_NOT_FOUND, '0, '0, '0, 2));
    add_row(OP_REMOVE, '1, '0, '0, 8'd0, 1, 1'b1, mk_res(ST_OK, '0, '0, '0, 1));
    add_row(OP_AT_IDX, '0, '0, '0, 8'd0, 1, 1'b1, mk_res(ST_OK, '0, '0, 64'h41, 1));
    add_row(OP_SET, 64'h30, 64'hDEAD_BEEF_5A5A_0F0F, 32'hCAFE_0001, 8'd0, 15, 1'b0, '0);
    add_row(OP_SET, 64'h5A, '1, '1, 8'd0, 1, 1'b1, mk_res(ST_FULL, '0, '0, '0, 16));
    add_row(OP_SET, 64'h41, 64'h8000_0000_0000_0001, 32'h8000_0001, 8'd0, 1, 1'b1,
            mk_res(ST_OK, '0, '0, '0, 16));
    add_row(OP_LOOKUP, 64'h41, '0, '0, 8'd0, 1, 1'b0, '0);
    add_row(OP_REMOVE, 64'h35, '0, '0, 8'd0, 1, 1'b1, mk_res(ST_OK, '0, '0, '0, 15));
    add_row(OP_AT_IDX, '0, '0, '0, 8'd15, 1, 1'b1, mk_res(ST_NOT_FOUND, '0, '0, '0, 15));
    add_row(OP_AT_IDX, '0, '0, '0, 8'd14, 1, 1'b0, '0);
    add_row(OP_LOOKUP, 64'h35, '0, '0, 8'd0, 1, 1'b1, mk_res(ST_NOT_FOUND, '0, '0, '0, 15));
    add_row(OP_REMOVE, 64'h3E, '0, '0, 8'd0, 1, 1'b1, mk_res(ST_OK, '0, '0, '0, 14));
    add_row(OP_AT_IDX, '0, '0, '0, 8'd0, 1, 1'b0, '0);

    // Hold reset, then release it
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; a repeated row steps the identifier's low byte
    foreach (rows[r]) begin
      for (int i = 0; i < rows[r].rep; i++) begin
        item = rows[r].item;
        item.ident = item.ident + 64'(i);
        send(item, rows[r].typed && rows[r].rep == 1, rows[r].res, $urandom_range(0, 13));
      end
    end

    // Random traffic in segments that fill, drain or mix, some without idle gaps
    for (int s = 0; s < SEG_COUNT; s++) begin
      mode = seg_mode_t'($urandom_range(0, 2));
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        gap = quiet ? 0 : $urandom_range(0, 13);
        send(gen_item(mode), 1'b0, '0, gap);
      end
    end

    // Drop start and let the last results come out
    start       <= 1'b0;
    fixed_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d operations accepted, %0d results checked, %0d mismatches",
             n_accepted, n_results, err_count);
    $display("statuses seen: ok %0d, invalid %0d, full %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_FULL],
             status_seen[ST_NOT_FOUND]);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
